// ----- rtl/hysteresis_gate_transition_queue_macros.svh -----
// Assertion macros for the gate channel checker.
`ifndef HYSTERESIS_GATE_TRANSITION_QUEUE_MACROS_SVH
`define HYSTERESIS_GATE_TRANSITION_QUEUE_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define HGTQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define HGTQ_ASSERT(lbl, prop, msg) \
  `HGTQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/hgtq_pkg.sv -----
// Shared types and constants of the gate channel transition queue.
package hgtq_pkg;

  localparam int unsigned VoltW   = 15;
  localparam int unsigned PendW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_HIGH_THR = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_THR  = 1'b1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic signed [VoltW-1:0] HIGH_THR_RST = 15'sd1000;
  localparam logic signed [VoltW-1:0] LOW_THR_RST  = 15'sd500;

  typedef struct packed {
    logic             valid;
    logic             from_mem;
    logic             level;
    logic             link;
    logic [PendW-1:0] pending;
  } tick_t;

endpackage

// ----- rtl/hgtq_ram.sv -----
// Level queue storage: one write port, one registered read port.
module hgtq_ram #(
  parameter int unsigned QUEUE_DEPTH = 8,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem [QUEUE_DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hgtq_ctrl.sv -----
// Threshold registers, Schmitt compare and queue pointer control.
module hgtq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 8,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [hgtq_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic signed [hgtq_pkg::VoltW-1:0]      cfg_wdata_i,
  input  logic                                   accept_i,
  input  logic                                   func_i,
  input  logic                                   connected_i,
  input  logic signed [hgtq_pkg::VoltW-1:0]      voltage_mv_i,
  output logic                                   mem_we_o,
  output logic [AW-1:0]                          mem_waddr_o,
  output logic                                   mem_wdata_o,
  output logic                                   mem_re_o,
  output logic [AW-1:0]                          mem_raddr_o,
  output hgtq_pkg::tick_t                        tick_o
);

  import hgtq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [VoltW-1:0] high_thr_q, low_thr_q;
  logic                    link_q, link_d;
  logic                    sampled_q, sampled_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    lvl;
  logic [AW:0]             wsum;
  logic [AW-1:0]           wpos;
  logic [AW-1:0]           head_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HIGH_THR_RST;
      low_thr_q  <= LOW_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_THR: high_thr_q <= cfg_wdata_i;
        CFG_LOW_THR:  low_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q    <= 1'b0;
      sampled_q <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
    end else begin
      link_q    <= link_d;
      sampled_q <= sampled_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
    end
  end

  // Disconnect clears the link, level, head and count state, so a down link always holds zeros here.
  assign lvl      = sampled_q ? (voltage_mv_i > low_thr_q) : (voltage_mv_i >= high_thr_q);
  assign wsum     = {1'b0, head_q} + (AW+1)'(cnt_q);
  assign wpos     = (wsum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH))
                                                   : wsum[AW-1:0];
  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    link_d      = link_q;
    sampled_d   = sampled_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wpos;
    mem_wdata_o = lvl;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    tick_o      = '0;
    if (accept_i) begin
      if (func_i == FUNC_SAMPLE) begin
        if (!connected_i) begin
          link_d    = 1'b0;
          sampled_d = 1'b0;
          head_d    = '0;
          cnt_d     = '0;
        end else begin
          link_d = 1'b1;
          if (lvl != sampled_q) begin
            sampled_d = lvl;
            mem_we_o  = 1'b1;
            if (cnt_q < CW'(QUEUE_DEPTH)) begin
              cnt_d = cnt_q + CW'(1);
            end else begin
              head_d      = '0;
              cnt_d       = CW'(1);
              mem_waddr_o = '0;
            end
          end
        end
      end else begin
        tick_o.valid = 1'b1;
        tick_o.link  = link_q;
        if (link_q && (cnt_q != '0)) begin
          tick_o.from_mem = 1'b1;
          tick_o.pending  = PendW'(cnt_q - CW'(1));
          mem_re_o        = 1'b1;
          head_d          = head_inc;
          cnt_d           = cnt_q - CW'(1);
        end else begin
          tick_o.level = sampled_q;
        end
      end
    end
  end

endmodule

// ----- rtl/hgtq_outq.sv -----
// Read-data stage and output register for tick results.
module hgtq_outq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hgtq_pkg::tick_t            tick_i,
  input  logic                       mem_rdata_i,
  input  logic                       out_stall_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  output logic                       scheduler_level_o,
  output logic                       input_connected_o,
  output logic [hgtq_pkg::PendW-1:0] pending_count_o
);

  import hgtq_pkg::*;

  logic             s1_valid_q;
  tick_t            s1_q;
  logic             out_valid_q;
  logic             out_level_q;
  logic             out_link_q;
  logic [PendW-1:0] out_pend_q;
  logic             advance;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_i.valid) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid) begin
      s1_q <= tick_i;
    end
    if (advance && s1_valid_q) begin
      out_level_q <= s1_q.from_mem ? mem_rdata_i : s1_q.level;
      out_link_q  <= s1_q.link;
      out_pend_q  <= s1_q.pending;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scheduler_level_o = out_level_q;
  assign input_connected_o = out_link_q;
  assign pending_count_o   = out_pend_q;

endmodule

// ----- rtl/hysteresis_gate_transition_queue.sv -----
// Top level of one gate input channel with Schmitt trigger and transition queue.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, func_i, connected_i,     | beat in
//          | voltage_mv_i                                     |
//  out     | out_valid_o, out_stall_i, scheduler_level_o,     | beat out
//          | input_connected_o, pending_count_o               |
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | write only
//
// One input beat per cycle while the input is not stalled. A tick beat passes
// through the queue memory read stage and then the output register.
// Sample beats give no result. Reset needs no clearing pass.
// The input stalls only while the read stage is full and the output is stalled.
module hysteresis_gate_transition_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hgtq_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic signed [hgtq_pkg::VoltW-1:0]     cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  func_i,
  input  logic                                  connected_i,
  input  logic signed [hgtq_pkg::VoltW-1:0]     voltage_mv_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  scheduler_level_o,
  output logic                                  input_connected_o,
  output logic [hgtq_pkg::PendW-1:0]            pending_count_o
);

  import hgtq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;
  tick_t         tick;

  assign accept = in_valid_i && !in_stall_o;

  hgtq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .func_i      (func_i),
    .connected_i (connected_i),
    .voltage_mv_i(voltage_mv_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .tick_o      (tick)
  );

  hgtq_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  hgtq_outq u_outq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick),
    .mem_rdata_i      (mem_rdata),
    .out_stall_i      (out_stall_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .scheduler_level_o(scheduler_level_o),
    .input_connected_o(input_connected_o),
    .pending_count_o  (pending_count_o)
  );

endmodule

// ----- rtl/hgtq_checker.sv -----
// Port-level assertions for the gate channel, bound to the top level.
`include "hysteresis_gate_transition_queue_macros.svh"

module hgtq_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_we_i,
  input logic [hgtq_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input logic signed [hgtq_pkg::VoltW-1:0]     cfg_wdata_i,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  func_i,
  input logic                                  connected_i,
  input logic signed [hgtq_pkg::VoltW-1:0]     voltage_mv_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  scheduler_level_o,
  input logic                                  input_connected_o,
  input logic [hgtq_pkg::PendW-1:0]            pending_count_o
);

  import hgtq_pkg::*;

  `HGTQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(scheduler_level_o) && $stable(input_connected_o) && $stable(pending_count_o), "stalled output beat changed")

  `HGTQ_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")

  `HGTQ_ASSERT(a_down_quiet, out_valid_o && !input_connected_o |-> !scheduler_level_o && (pending_count_o == '0), "disconnected tick reports level or pending")

  `HGTQ_ASSERT(a_rise_from_tick, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && (func_i == FUNC_TICK), 2), "output beat without a tick beat")

endmodule

bind hysteresis_gate_transition_queue hgtq_checker u_hgtq_checker (.*);
